FILE: hdl/per_bin_majority_vote_consensus_top_defines.svh
// Assertion macros for the per-bin majority vote consensus block.
// Included by the top level; relies on clk_i and rst_ni being in scope.
`ifndef PER_BIN_MAJORITY_VOTE_CONSENSUS_TOP_DEFINES_SVH
`define PER_BIN_MAJORITY_VOTE_CONSENSUS_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBMV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be true.
`define PBMV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: hdl/pbmv_pkg.sv
// Shared types and constants of the per-bin majority vote consensus block.
// No dependencies.
`timescale 1ns / 1ps

package pbmv_pkg;

  // Default table geometry.
  localparam int unsigned BinsDefault     = 4096;
  localparam int unsigned VoteBitsDefault = 24;

  // Fixed field widths of the stream items.
  localparam int unsigned BinIdxW = 12;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned TotalW  = 13;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Operation carried in the request's tuser.
  typedef enum logic [1:0] {
    MODE_VOTE    = 2'd0,
    MODE_CMP     = 2'd1,
    MODE_PRELOAD = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

endpackage

FILE: hdl/per_bin_majority_vote_consensus_top.sv
// Top level of the per-bin majority vote consensus block.
// Depends on pbmv_pkg and per_bin_majority_vote_consensus_top_defines.svh.
`timescale 1ns / 1ps
`include "per_bin_majority_vote_consensus_top_defines.svh"

// Keeps a majority candidate and vote count per bin in an on-chip memory and
// accepts one request per cycle: the memory is read when a request is taken,
// and the entry is updated and written back from the update stage, with the
// last write forwarded when consecutive requests hit the same bin. A compare
// request with tlast set delivers the mismatch and compared-bin counts through
// the update stage and the output register; such a request holds the update
// stage, and with it the input, only while the previous result still sits
// unread in the output register. After reset the block clears the table and
// takes no request during that time.
module per_bin_majority_vote_consensus_top #(
  parameter int unsigned BINS      = pbmv_pkg::BinsDefault,
  parameter int unsigned VOTE_BITS = pbmv_pkg::VoteBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // bin_index [11:0], bin_value [27:12], zero [31:28]
  input  logic [1:0]  s_axis_tuser_i,  // mode [1:0]
  input  logic        s_axis_tlast_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // mismatch_count [12:0], bins_compared [25:13], zero [31:26]
);

  localparam int unsigned AW     = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned IdxW   = pbmv_pkg::BinIdxW;
  localparam int unsigned ValW   = pbmv_pkg::ValueW;
  localparam int unsigned TotW   = pbmv_pkg::TotalW;
  localparam logic [AW-1:0] LastAddr = AW'(BINS - 1);
  localparam logic [VOTE_BITS-1:0] VoteMax = {VOTE_BITS{1'b1}};

  // Table memories.
  logic [ValW-1:0]      cand_mem [BINS];
  logic [VOTE_BITS-1:0] vote_mem [BINS];
  logic [ValW-1:0]      rd_cand_q;
  logic [VOTE_BITS-1:0] rd_vote_q;

  // Clearing pass after reset.
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // Update stage.
  logic             s1_vld_q, s1_vld_d;
  pbmv_pkg::mode_e  s1_mode_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [ValW-1:0]  s1_val_q;
  logic             s1_last_q;

  // Forwarding of the write made at the edge a request was taken.
  logic                 fwd_vld_q, fwd_vld_d;
  logic [IdxW-1:0]      fwd_idx_q;
  logic [ValW-1:0]      fwd_cand_q;
  logic [VOTE_BITS-1:0] fwd_vote_q;

  // Running totals and output register.
  logic [TotW-1:0] mis_tot_q, mis_tot_d;
  logic [TotW-1:0] cmp_tot_q, cmp_tot_d;
  logic            out_vld_q, out_vld_d;
  logic [TotW-1:0] out_mis_q, out_cmp_q;

  // Stage logic.
  logic                 accept;
  logic                 s1_adv;
  logic                 s1_emit;
  logic                 s1_in_range;
  logic                 fwd_hit;
  logic [ValW-1:0]      eff_cand;
  logic [VOTE_BITS-1:0] eff_vote;
  logic [ValW-1:0]      new_cand;
  logic [VOTE_BITS-1:0] new_vote;
  logic                 s1_we;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ValW-1:0]      mem_wcand;
  logic [VOTE_BITS-1:0] mem_wvote;
  logic [TotW-1:0]      mis_inc, cmp_inc;
  logic [IdxW-1:0]      in_idx;
  logic [ValW-1:0]      in_val;

  assign in_idx = s_axis_tdata_i[IdxW-1:0];
  assign in_val = s_axis_tdata_i[IdxW+ValW-1:IdxW];

  // Handshake: a frame-end compare waits only on a full output register.
  assign s1_emit = (s1_mode_q == pbmv_pkg::MODE_CMP) && s1_last_q;
  assign s1_adv  = s1_vld_q && !(s1_emit && out_vld_q && !m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy_q && (!s1_vld_q || s1_adv);
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  // Resolve the entry seen by the update stage.
  assign s1_in_range = (32'(s1_idx_q) < 32'(BINS));
  assign fwd_hit     = fwd_vld_q && (fwd_idx_q == s1_idx_q);

  always_comb begin
    if (!s1_in_range) begin
      eff_cand = '0;
      eff_vote = '0;
    end else if (fwd_hit) begin
      eff_cand = fwd_cand_q;
      eff_vote = fwd_vote_q;
    end else begin
      eff_cand = rd_cand_q;
      eff_vote = rd_vote_q;
    end
  end

  // New entry value for each operation.
  always_comb begin
    new_cand = eff_cand;
    new_vote = eff_vote;
    unique case (s1_mode_q)
      pbmv_pkg::MODE_VOTE: begin
        if (eff_vote == '0) begin
          new_cand = s1_val_q;
          new_vote = VOTE_BITS'(1);
        end else if (s1_val_q == eff_cand) begin
          if (eff_vote != VoteMax) begin
            new_vote = eff_vote + VOTE_BITS'(1);
          end
        end else begin
          new_vote = eff_vote - VOTE_BITS'(1);
        end
      end
      pbmv_pkg::MODE_CMP: begin
        new_cand = eff_cand;
        new_vote = eff_vote;
      end
      pbmv_pkg::MODE_PRELOAD: begin
        new_cand = s1_val_q;
        new_vote = VOTE_BITS'(1);
      end
      pbmv_pkg::MODE_CLEAR: begin
        new_cand = '0;
        new_vote = '0;
      end
      default: begin
        new_cand = eff_cand;
        new_vote = eff_vote;
      end
    endcase
  end

  assign s1_we = s1_adv && s1_in_range && (s1_mode_q != pbmv_pkg::MODE_CMP);

  // Memory write port: the clearing pass or the update stage.
  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wcand = '0;
      mem_wvote = '0;
    end else begin
      mem_we    = s1_we;
      mem_waddr = AW'(s1_idx_q);
      mem_wcand = new_cand;
      mem_wvote = new_vote;
    end
  end

  // Table memories with registered read; a waiting request keeps its resolved entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cand_mem[mem_waddr] <= mem_wcand;
      vote_mem[mem_waddr] <= mem_wvote;
    end
    if (accept) begin
      rd_cand_q <= cand_mem[AW'(in_idx)];
      rd_vote_q <= vote_mem[AW'(in_idx)];
    end else if (s1_vld_q) begin
      rd_cand_q <= eff_cand;
      rd_vote_q <= eff_vote;
    end
  end

  // Clearing pass sequencing.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  // Saturating totals and result capture.
  assign cmp_inc = (cmp_tot_q != pbmv_pkg::TotalMax) ? cmp_tot_q + TotW'(1) : cmp_tot_q;
  assign mis_inc = (mis_tot_q != pbmv_pkg::TotalMax) ? mis_tot_q + TotW'(1) : mis_tot_q;

  always_comb begin
    mis_tot_d = mis_tot_q;
    cmp_tot_d = cmp_tot_q;
    if (s1_adv && (s1_mode_q == pbmv_pkg::MODE_CMP)) begin
      if (s1_last_q) begin
        mis_tot_d = '0;
        cmp_tot_d = '0;
      end else begin
        cmp_tot_d = cmp_inc;
        mis_tot_d = (s1_val_q != eff_cand) ? mis_inc : mis_tot_q;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_adv && s1_emit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Stage occupancy and forwarding control.
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  assign fwd_vld_d = s1_we && accept;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_vld_q   <= 1'b0;
      fwd_vld_q  <= 1'b0;
      mis_tot_q  <= '0;
      cmp_tot_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      s1_vld_q   <= s1_vld_d;
      fwd_vld_q  <= fwd_vld_d;
      mis_tot_q  <= mis_tot_d;
      cmp_tot_q  <= cmp_tot_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= pbmv_pkg::mode_e'(s_axis_tuser_i);
      s1_idx_q  <= in_idx;
      s1_val_q  <= in_val;
      s1_last_q <= s_axis_tlast_i;
    end
    if (s1_we) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_cand_q <= new_cand;
      fwd_vote_q <= new_vote;
    end
    if (s1_adv && s1_emit) begin
      out_cmp_q <= cmp_inc;
      out_mis_q <= (s1_val_q != eff_cand) ? mis_inc : mis_tot_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(32 - 2 * TotW)'(0), out_cmp_q, out_mis_q};

  // Checks on the block's own sequencing.
  `PBMV_ASSERT_NEVER(a_no_req_while_clearing, clr_busy_q && s_axis_tready_o, "request taken during clearing pass")
  `PBMV_ASSERT_NEVER(a_no_stage_while_clearing, clr_busy_q && s1_vld_q, "update stage busy during clearing pass")
  `PBMV_ASSERT_IMP(a_result_from_frame_end, out_vld_q && !$past(out_vld_q), $past(s1_vld_q && s1_emit), "result without frame-end compare")
  `PBMV_ASSERT_IMP(a_mismatch_bounded, out_vld_q, out_mis_q <= out_cmp_q, "mismatch count exceeds bins compared")

endmodule
